### sv/lvd_pkg.sv
package lvd_pkg;

    // element and arithmetic widths
    localparam int ELEM_W = 16;
    localparam int DIFF_W = ELEM_W + 1;
    localparam int MAG_W  = ELEM_W;
    localparam int TERM_W = 2 * MAG_W;
    localparam int ACC_W  = 45;
    localparam int DIST_W = 28;

    // square root unit: two radicand bits per step
    localparam int RAD_W  = ACC_W + 1;
    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 3;
    localparam int ITER_W = $clog2(ROOT_W);

    localparam logic [ACC_W-1:0]  ACC_MAX  = {ACC_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    // controller states
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_ACC  = 6'b000100,
        ST_FIN  = 6'b001000,
        ST_SQRT = 6'b010000,
        ST_OUT  = 6'b100000
    } lvd_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic do_mul;
        logic do_acc;
        logic sqrt_start;
        logic sqrt_step;
        logic out_load;
    } lvd_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_last;
        logic item_l1;
        logic sqrt_last;
        logic out_free;
    } lvd_status_t;

endpackage

### sv/l1_l2_vector_distance_top.sv
// element pairs: a new request is taken only back in idle, after the difference, multiply and accumulate steps
// last pair, L1 mode: the FIN and OUT states load the clipped sum into the output register once it is free
// last pair, L2 mode: the result passes the FIN, SQRT and OUT states, the square root retiring 2 bits per cycle
// a finished result waits in the output register while the next vector is taken
// aresetn is synchronous, active low: clears mode (Euclidean), sum, overflow flag, output valid
module l1_l2_vector_distance_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [lvd_pkg::ELEM_W-1:0] s_value_a,
    input  logic signed [lvd_pkg::ELEM_W-1:0] s_value_b,
    input  logic                              s_last_element,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lvd_pkg::DIST_W-1:0]        m_distance,
    output logic                              m_saturated
);

    lvd_pkg::lvd_cmd_t    cmd;
    lvd_pkg::lvd_status_t status;

    // mode register always takes the write
    assign cfg_ready = 1'b1;

    lvd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    lvd_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .s_value_a      (s_value_a),
        .s_value_b      (s_value_b),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance     (m_distance),
        .m_saturated    (m_saturated),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

### sv/lvd_ctrl.sv
module lvd_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  lvd_pkg::lvd_status_t status,
    output lvd_pkg::lvd_cmd_t    cmd
);

    lvd_pkg::lvd_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lvd_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == lvd_pkg::ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            lvd_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = lvd_pkg::ST_MUL;
                end
            end
            lvd_pkg::ST_MUL: begin
                cmd.do_mul = 1'b1;
                state_next = lvd_pkg::ST_ACC;
            end
            lvd_pkg::ST_ACC: begin
                cmd.do_acc = 1'b1;
                state_next = status.item_last ? lvd_pkg::ST_FIN : lvd_pkg::ST_IDLE;
            end
            lvd_pkg::ST_FIN: begin
                if (status.item_l1) begin
                    state_next = lvd_pkg::ST_OUT;
                end else begin
                    cmd.sqrt_start = 1'b1;
                    state_next     = lvd_pkg::ST_SQRT;
                end
            end
            lvd_pkg::ST_SQRT: begin
                cmd.sqrt_step = 1'b1;
                if (status.sqrt_last) begin
                    state_next = lvd_pkg::ST_OUT;
                end
            end
            lvd_pkg::ST_OUT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = lvd_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lvd_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### sv/lvd_datapath.sv
module lvd_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    input  logic                              cfg_data,
    input  logic signed [lvd_pkg::ELEM_W-1:0] s_value_a,
    input  logic signed [lvd_pkg::ELEM_W-1:0] s_value_b,
    input  logic                              s_last_element,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [lvd_pkg::DIST_W-1:0]        m_distance,
    output logic                              m_saturated,
    input  lvd_pkg::lvd_cmd_t                 cmd,
    output lvd_pkg::lvd_status_t              status
);

    logic                        use_l1_reg;
    logic [lvd_pkg::MAG_W-1:0]   mag_reg;
    logic                        item_l1_reg;
    logic                        item_last_reg;
    logic [lvd_pkg::TERM_W-1:0]  term_reg;
    logic [lvd_pkg::ACC_W-1:0]   sum_reg;
    logic                        ovf_reg;
    logic [lvd_pkg::RAD_W-1:0]   rad_reg;
    logic [lvd_pkg::REM_W-1:0]   rem_reg;
    logic [lvd_pkg::ROOT_W-1:0]  root_reg;
    logic [lvd_pkg::ITER_W-1:0]  iter_reg;
    logic                        m_valid_reg;
    logic [lvd_pkg::DIST_W-1:0]  dist_reg;
    logic                        sat_reg;

    logic [lvd_pkg::DIFF_W-1:0]  diff;
    logic [lvd_pkg::DIFF_W-1:0]  neg_diff;
    logic [lvd_pkg::MAG_W-1:0]   mag_next;
    logic [lvd_pkg::TERM_W-1:0]  term_next;
    logic [lvd_pkg::ACC_W:0]     sum_wide;
    logic [lvd_pkg::REM_W-1:0]   rem_shift;
    logic [lvd_pkg::REM_W-1:0]   trial;
    logic                        trial_ok;
    logic                        l1_clip;
    logic [lvd_pkg::DIST_W-1:0]  dist_next;
    logic                        sat_next;

    // difference magnitude of the two elements
    assign diff     = {s_value_a[lvd_pkg::ELEM_W-1], s_value_a}
                    - {s_value_b[lvd_pkg::ELEM_W-1], s_value_b};
    assign neg_diff = ~diff + 1'b1;
    assign mag_next = diff[lvd_pkg::DIFF_W-1] ? neg_diff[lvd_pkg::MAG_W-1:0]
                                              : diff[lvd_pkg::MAG_W-1:0];

    // absolute or squared term
    assign term_next = item_l1_reg ? lvd_pkg::TERM_W'(mag_reg)
                                   : lvd_pkg::TERM_W'(mag_reg) * lvd_pkg::TERM_W'(mag_reg);

    // saturating accumulate
    assign sum_wide = {1'b0, sum_reg} + (lvd_pkg::ACC_W + 1)'(term_reg);

    // one restoring square root step
    assign rem_shift = {rem_reg[lvd_pkg::REM_W-3:0], rad_reg[lvd_pkg::RAD_W-1 -: 2]};
    assign trial     = {1'b0, root_reg, 2'b01};
    assign trial_ok  = (rem_shift >= trial);

    // result formatting
    assign l1_clip   = (sum_reg[lvd_pkg::ACC_W-1:lvd_pkg::DIST_W] != '0);
    assign dist_next = item_l1_reg ? (l1_clip ? lvd_pkg::DIST_MAX
                                              : sum_reg[lvd_pkg::DIST_W-1:0])
                                   : lvd_pkg::DIST_W'(root_reg);
    assign sat_next  = ovf_reg | (item_l1_reg & l1_clip);

    // mode register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_l1_reg <= 1'b0;
        end else if (cfg_valid) begin
            use_l1_reg <= cfg_data;
        end
    end

    // item and term registers
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            mag_reg       <= mag_next;
            item_l1_reg   <= use_l1_reg;
            item_last_reg <= s_last_element;
        end
        if (cmd.do_mul) begin
            term_reg <= term_next;
        end
    end

    // accumulator and overflow flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.out_load) begin
            sum_reg <= '0;
            ovf_reg <= 1'b0;
        end else if (cmd.do_acc) begin
            if (sum_wide[lvd_pkg::ACC_W]) begin
                sum_reg <= lvd_pkg::ACC_MAX;
                ovf_reg <= 1'b1;
            end else begin
                sum_reg <= sum_wide[lvd_pkg::ACC_W-1:0];
            end
        end
    end

    // square root iteration
    always_ff @(posedge aclk) begin
        if (cmd.sqrt_start) begin
            rad_reg  <= lvd_pkg::RAD_W'(sum_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            iter_reg <= '0;
        end else if (cmd.sqrt_step) begin
            rad_reg  <= rad_reg << 2;
            rem_reg  <= trial_ok ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[lvd_pkg::ROOT_W-2:0], trial_ok};
            iter_reg <= iter_reg + 1'b1;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            dist_reg <= dist_next;
            sat_reg  <= sat_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_distance  = dist_reg;
    assign m_saturated = sat_reg;

    // status back to the controller
    assign status.item_last = item_last_reg;
    assign status.item_l1   = item_l1_reg;
    assign status.sqrt_last = (iter_reg == lvd_pkg::ITER_W'(lvd_pkg::ROOT_W - 1));
    assign status.out_free  = ~m_valid_reg | m_ready;

endmodule

### sv/lvd_checker.sv
module lvd_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic                              cfg_data,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic signed [lvd_pkg::ELEM_W-1:0] s_value_a,
    input logic signed [lvd_pkg::ELEM_W-1:0] s_value_b,
    input logic                              s_last_element,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic [lvd_pkg::DIST_W-1:0]        m_distance,
    input logic                              m_saturated
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_distance) && $stable(m_saturated))
        else $error("result changed while stalled");

    // one request in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request taken while previous still in work");

    // no result appears right after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // a new result only follows a busy period
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(!s_ready))
        else $error("result without finishing step");

endmodule

bind l1_l2_vector_distance_top lvd_checker u_lvd_checker (.*);

### tb/sv/tb_l1_l2_vector_distance_top.sv
module tb_l1_l2_vector_distance_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    // longest path is the L2 square root
    localparam int DRAIN_CYCLES  = 40;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 265;
    localparam int SEND_IDLE_PCT = 32;
    localparam int RECV_IDLE_PCT = 69;

    localparam logic MODE_L2 = 1'b0;
    localparam logic MODE_L1 = 1'b1;

    typedef enum logic [0:0] {
        ROW_PAIR,
        ROW_CFG
    } row_kind_t;

    typedef struct packed {
        logic [lvd_pkg::DIST_W-1:0] distance;
        logic                       sat;
    } dist_t;

    // directed stimulus: a pair repeated reps times, or a mode write
    typedef struct packed {
        row_kind_t                         kind;
        logic signed [lvd_pkg::ELEM_W-1:0] a;
        logic signed [lvd_pkg::ELEM_W-1:0] b;
        logic                              last;
        int                                reps;
        logic                              typed;
        logic [lvd_pkg::DIST_W-1:0]        distance;
        logic                              sat;
        logic                              mode;
    } row_t;

    localparam row_t DIR_ROWS [23] = '{
        // right after reset: Euclidean mode, empty sum
        '{ROW_PAIR, 0, 0, 1, 1, 1, 0, 0, MODE_L2},
        '{ROW_PAIR, 32767, -32768, 1, 1, 1, 65535, 0, MODE_L2},
        '{ROW_PAIR, -32768, 32767, 1, 1, 1, 65535, 0, MODE_L2},
        '{ROW_PAIR, 32767, 32767, 0, 1, 0, 0, 0, MODE_L2},
        '{ROW_PAIR, -1, 0, 0, 1, 0, 0, 0, MODE_L2},
        '{ROW_PAIR, 5, -7, 1, 1, 0, 0, 0, MODE_L2},
        // sum of absolute differences
        '{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, MODE_L1},
        '{ROW_PAIR, 32767, -32768, 1, 1, 1, 65535, 0, MODE_L1},
        '{ROW_PAIR, -32768, -32768, 0, 1, 0, 0, 0, MODE_L1},
        '{ROW_PAIR, 100, -200, 0, 1, 0, 0, 0, MODE_L1},
        '{ROW_PAIR, -3, 4, 1, 1, 0, 0, 0, MODE_L1},
        '{ROW_PAIR, 0, 0, 1, 1, 1, 0, 0, MODE_L1},
        // mode flips with a vector half done
        '{ROW_PAIR, 1000, -1000, 0, 1, 0, 0, 0, MODE_L1},
        '{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, MODE_L2},
        '{ROW_PAIR, 3, 0, 0, 1, 0, 0, 0, MODE_L2},
        '{ROW_PAIR, 0, 4, 1, 1, 0, 0, 0, MODE_L2},
        // squares piled up, then read out as an L1 sum: output clamps
        '{ROW_PAIR, 32767, -32768, 0, 4, 0, 0, 0, MODE_L2},
        '{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, MODE_L1},
        '{ROW_PAIR, 0, 0, 1, 1, 1, lvd_pkg::DIST_MAX, 1, MODE_L1},
        // long vector of the largest squares
        '{ROW_CFG, 0, 0, 0, 0, 0, 0, 0, MODE_L2},
        '{ROW_PAIR, 32767, -32768, 0, 40, 0, 0, 0, MODE_L2},
        '{ROW_PAIR, 1, 1, 1, 1, 0, 0, 0, MODE_L2},
        // flag and sum cleared after the long vector
        '{ROW_PAIR, 0, 0, 1, 1, 1, 0, 0, MODE_L2}
    };

    logic                              aclk;
    logic                              aresetn;
    logic                              cfg_valid;
    logic                              cfg_ready;
    logic                              cfg_data;
    logic                              s_valid;
    logic                              s_ready;
    logic signed [lvd_pkg::ELEM_W-1:0] s_value_a;
    logic signed [lvd_pkg::ELEM_W-1:0] s_value_b;
    logic                              s_last_element;
    logic                              m_valid;
    logic                              m_ready;
    logic [lvd_pkg::DIST_W-1:0]        m_distance;
    logic                              m_saturated;

    // predictor state
    logic [lvd_pkg::ACC_W-1:0] sum_acc   = '0;
    logic                      sum_ovf   = 1'b0;
    logic                      mode_l1   = MODE_L2;
    dist_t                     pending_distances[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int cycle_count   = 0;
    int errors        = 0;
    int pairs_sent    = 0;
    int dist_checked  = 0;
    int sat_seen      = 0;
    int l1_results    = 0;
    int mode_writes   = 0;

    l1_l2_vector_distance_top uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_value_a      (s_value_a),
        .s_value_b      (s_value_b),
        .s_last_element (s_last_element),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_distance     (m_distance),
        .m_saturated    (m_saturated)
    );

    // clock
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // run guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Regression FAIL");
            $finish;
        end
    end

    // bitwise floor square root, one root bit per step from the top
    function automatic logic [lvd_pkg::ROOT_W-1:0] floor_root(
        input logic [lvd_pkg::ACC_W-1:0] x);
        logic [lvd_pkg::ROOT_W-1:0] root;
        logic [lvd_pkg::ROOT_W-1:0] trial;
        root = '0;
        for (int i = lvd_pkg::ROOT_W - 1; i >= 0; i--) begin
            trial = root | (lvd_pkg::ROOT_W'(1) << i);
            if (64'(trial) * 64'(trial) <= 64'(x)) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // adds one pair to the running sum, forms the distance on the last pair
    task automatic accumulate_pair(input logic signed [lvd_pkg::ELEM_W-1:0] a,
                                   input logic signed [lvd_pkg::ELEM_W-1:0] b,
                                   input logic last, output logic emits,
                                   output dist_t res);
        logic signed [lvd_pkg::ELEM_W:0] diff;
        logic [lvd_pkg::ELEM_W:0]        mag;
        logic [lvd_pkg::ACC_W-1:0]       term;
        diff = {a[lvd_pkg::ELEM_W-1], a} - {b[lvd_pkg::ELEM_W-1], b};
        mag  = diff[lvd_pkg::ELEM_W] ? -diff : diff;
        term = mode_l1 ? lvd_pkg::ACC_W'(mag)
                       : lvd_pkg::ACC_W'(mag) * lvd_pkg::ACC_W'(mag);
        if (term > lvd_pkg::ACC_MAX - sum_acc) begin
            sum_acc = lvd_pkg::ACC_MAX;
            sum_ovf = 1'b1;
        end else begin
            sum_acc = sum_acc + term;
        end
        emits = last;
        res   = '0;
        if (last) begin
            res.sat = sum_ovf;
            if (mode_l1) begin
                if (sum_acc > lvd_pkg::ACC_W'(lvd_pkg::DIST_MAX)) begin
                    res.distance = lvd_pkg::DIST_MAX;
                    res.sat      = 1'b1;
                end else begin
                    res.distance = sum_acc[lvd_pkg::DIST_W-1:0];
                end
            end else begin
                res.distance = lvd_pkg::DIST_W'(floor_root(sum_acc));
            end
            sum_acc = '0;
            sum_ovf = 1'b0;
        end
    endtask

    // one element pair request; leaves s_valid high on return
    task automatic send_pair(input logic signed [lvd_pkg::ELEM_W-1:0] a,
                             input logic signed [lvd_pkg::ELEM_W-1:0] b,
                             input logic last, input logic typed,
                             input dist_t typed_res);
        logic  emits;
        dist_t res;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_value_a      <= a;
        s_value_b      <= b;
        s_last_element <= last;
        @(negedge aclk);
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        pairs_sent++;
        accumulate_pair(a, b, last, emits, res);
        if (emits) begin
            if (mode_l1) l1_results++;
            pending_distances.push_back(typed ? typed_res : res);
        end
    endtask

    // waits for every distance plus a quiet spell, then writes the mode
    task automatic write_mode(input logic mode);
        s_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= mode;
        @(negedge aclk);
        while (!cfg_ready) @(negedge aclk);
        @(posedge aclk);
        cfg_valid <= 1'b0;
        mode_l1 = mode;
        mode_writes++;
    endtask

    function automatic logic signed [lvd_pkg::ELEM_W-1:0] pick_elem();
        case ($urandom_range(7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return lvd_pkg::ELEM_W'($urandom_range(16)) - 16'sd8;
            default: return lvd_pkg::ELEM_W'($urandom);
        endcase
    endfunction

    // result side: random ready, compare each accepted distance
    initial begin
        dist_t want;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
            @(negedge aclk);
            if (m_valid && m_ready) begin
                if (pending_distances.size() == 0) begin
                    errors++;
                    $display("%0t: distance %0d with none outstanding", $time, m_distance);
                end else begin
                    want = pending_distances.pop_front();
                    dist_checked++;
                    if (want.sat) sat_seen++;
                    if (m_distance !== want.distance) begin
                        errors++;
                        $display("%0t: distance mismatch expected %0d actual %0d",
                                 $time, want.distance, m_distance);
                    end
                    if (m_saturated !== want.sat) begin
                        errors++;
                        $display("%0t: saturated mismatch expected %0b actual %0b",
                                 $time, want.sat, m_saturated);
                    end
                end
            end
        end
    end

    // stimulus
    initial begin
        dist_t typed_res;
        int    vec_left;
        logic  last;
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_data       <= 1'b0;
        s_valid        <= 1'b0;
        s_value_a      <= '0;
        s_value_b      <= '0;
        s_last_element <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        send_idle_pct = SEND_IDLE_PCT;
        recv_idle_pct = RECV_IDLE_PCT;
        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].kind == ROW_CFG) begin
                write_mode(DIR_ROWS[i].mode);
            end else begin
                typed_res.distance = DIR_ROWS[i].distance;
                typed_res.sat      = DIR_ROWS[i].sat;
                for (int k = 0; k < DIR_ROWS[i].reps; k++) begin
                    send_pair(DIR_ROWS[i].a, DIR_ROWS[i].b, DIR_ROWS[i].last,
                              DIR_ROWS[i].typed, typed_res);
                end
            end
        end

        // random vectors; a phase may stop mid-vector so the next mode applies
        vec_left = 0;
        for (int p = 0; p < RAND_PHASES; p++) begin
            case (p / 2)
                0: begin
                    send_idle_pct = SEND_IDLE_PCT;
                    recv_idle_pct = RECV_IDLE_PCT;
                end
                1: begin
                    send_idle_pct = RECV_IDLE_PCT;
                    recv_idle_pct = SEND_IDLE_PCT;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            write_mode((p % 2 == 0) ? MODE_L1 : MODE_L2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (vec_left == 0) begin
                    vec_left = ($urandom_range(9) == 0) ? $urandom_range(80, 40)
                                                        : $urandom_range(12, 1);
                end
                vec_left--;
                last = (vec_left == 0);
                send_pair(pick_elem(), pick_elem(), last, 1'b0, '0);
            end
        end

        // drain
        s_valid <= 1'b0;
        while (pending_distances.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d element pairs over %0d mode writes, both L1 and Euclidean", pairs_sent,
                 mode_writes);
        $display("%0d distances checked, %0d in L1 mode, %0d saturated", dist_checked,
                 l1_results, sat_seen);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches", errors);
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
